@@ sv/fbc64_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fbc64_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_CIPHER_KEY   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECRYPT_MODE = 1'b1;

    localparam int unsigned BLOCK_W         = 64;
    localparam int unsigned SUBKEYS_PER_RND = 12;

    // Twelve subkey bytes of one round, byte 0 in the low bits
    typedef logic [SUBKEYS_PER_RND-1:0][7:0] subkey_t;

    localparam logic [7:0] SBOX [256] = '{
        8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,
        8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
        8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,
        8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
        8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,
        8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
        8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,
        8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
        8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,
        8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
        8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,
        8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
        8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,
        8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
        8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,
        8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
        8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,
        8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
        8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,
        8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
        8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,
        8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
        8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,
        8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
        8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,
        8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
        8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,
        8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
        8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,
        8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
        8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,
        8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
    };

    // Four-step byte permutation of one 16-bit word
    function automatic logic [15:0] g_perm(
        input logic [15:0] w,
        input logic [7:0]  k0,
        input logic [7:0]  k1,
        input logic [7:0]  k2,
        input logic [7:0]  k3
    );
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        a = SBOX[w[7:0] ^ k0] ^ w[15:8];
        b = SBOX[a ^ k1] ^ w[7:0];
        c = SBOX[b ^ k2] ^ a;
        d = SBOX[c ^ k3] ^ b;
        return {c, d};
    endfunction

    // Subkeys of round rd: the key rotated left once more before each byte.
    // Called with a constant round number only, so this folds to wiring.
    function automatic subkey_t round_key(
        input logic [BLOCK_W-1:0] key,
        input int unsigned        rd
    );
        subkey_t          k;
        logic [BLOCK_W-1:0] rot;
        int unsigned      amt;
        int unsigned      sel;
        for (int unsigned j = 0; j < SUBKEYS_PER_RND; j++)
        begin
            amt  = (rd * SUBKEYS_PER_RND + j + 1) & (BLOCK_W - 1);
            rot  = (key << amt) | (key >> ((BLOCK_W - amt) & (BLOCK_W - 1)));
            sel  = (j & 3) + (((rd & 1) != 0) ? 4 : 0);
            k[j] = rot[8*sel +: 8];
        end
        return k;
    endfunction

    // One Feistel round on {w0, w1, w2, w3}, w0 in the top bits
    function automatic logic [BLOCK_W-1:0] fbc_round(
        input logic [BLOCK_W-1:0] w,
        input subkey_t            k
    );
        logic [15:0] t0;
        logic [15:0] t1;
        logic [15:0] f0;
        logic [15:0] f1;
        t0 = g_perm(w[63:48], k[0], k[1], k[2], k[3]);
        t1 = g_perm(w[47:32], k[4], k[5], k[6], k[7]);
        f0 = t0 + {t1[14:0], 1'b0} + {k[8], k[9]};
        f1 = {t0[14:0], 1'b0} + t1 + {k[10], k[11]};
        return {w[31:16] ^ f0, w[15:0] ^ f1, w[63:48], w[47:32]};
    endfunction

endpackage

`default_nettype wire

@@ sv/feistel_block_cipher_64.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+---------------------------------
// s_        | in        | s_tvalid/s_tready  | s_tdata[63:0]  = block_in
// m_        | out       | m_tvalid/m_tready  | m_tdata[63:0]  = block_out
// cfg_      | in        | cfg_we             | cfg_index, cfg_data (0 key, 1 mode)
//
// One block enters per cycle while no stall at m_ backs up every stage; the pipeline is
// one input whitening stage, one register stage per Feistel round (four chained F-table
// lookups and the mod 2^16 sums set the stage depth), one output register.
// Reset clears every valid bit and both configuration registers.
// A stall at m_ holds each occupied stage; an empty stage still takes data,
// so bubbles close up and s_tready stays high while any stage has room.
// Subkeys are pure wiring off the key register; write config only when idle.
module feistel_block_cipher_64 #(
    parameter int ROUND_COUNT = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [63:0] s_tdata,     // [63:0] block_in
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [63:0] m_tdata,     // [63:0] block_out
    input  wire logic        cfg_we,
    input  wire logic [fbc64_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0] cipher_key_reg;
    logic        decrypt_mode_reg;

    // Stage 0 holds the whitened block, stage r+1 the block after round r
    logic [63:0]          stage_reg  [0:ROUND_COUNT];
    logic [63:0]          stage_next [0:ROUND_COUNT];
    logic [ROUND_COUNT:0] valid_reg;
    logic [ROUND_COUNT:0] valid_next;
    // adv[k]: stage k may load this cycle; adv[ROUND_COUNT+1] is the output
    logic [ROUND_COUNT+1:0] adv;

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg   <= '0;
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fbc64_pkg::REG_CIPHER_KEY:   cipher_key_reg   <= cfg_data;
                fbc64_pkg::REG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // Advance chain: a stage loads when empty or when its successor loads
    assign adv[ROUND_COUNT+1] = !out_valid_reg || m_tready;

    for (genvar k = 0; k <= ROUND_COUNT; k++)
    begin : g_adv
        assign adv[k] = !valid_reg[k] || adv[k+1];
    end

    assign s_tready = adv[0];

    // Input whitening
    assign stage_next[0] = s_tdata ^ cipher_key_reg;
    assign valid_next[0] = s_tvalid;

    // Round stages; decryption takes the subkeys of the mirrored round
    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_round
        fbc64_pkg::subkey_t sk_enc;
        fbc64_pkg::subkey_t sk_dec;
        fbc64_pkg::subkey_t sk_sel;

        assign sk_enc = fbc64_pkg::round_key(cipher_key_reg, r);
        assign sk_dec = fbc64_pkg::round_key(cipher_key_reg, ROUND_COUNT - 1 - r);
        assign sk_sel = decrypt_mode_reg ? sk_dec : sk_enc;

        assign stage_next[r+1] = fbc64_pkg::fbc_round(stage_reg[r], sk_sel);
        assign valid_next[r+1] = valid_reg[r];
    end

    // Final word swap and output whitening
    assign out_data_next = {stage_reg[ROUND_COUNT][31:16], stage_reg[ROUND_COUNT][15:0],
                            stage_reg[ROUND_COUNT][63:48], stage_reg[ROUND_COUNT][47:32]}
                           ^ cipher_key_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k <= ROUND_COUNT; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
            if (adv[ROUND_COUNT+1])
            begin
                out_valid_reg <= valid_reg[ROUND_COUNT];
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= ROUND_COUNT; k++)
        begin
            if (adv[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
        if (adv[ROUND_COUNT+1])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // An accepted block occupies the first stage on the next edge
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted block missing from input stage");

    // A finished block with room downstream reaches the output register
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ROUND_COUNT] && adv[ROUND_COUNT+1]) |=> m_tvalid)
        else $error("last round stage did not reach output");

    // A stalled output holds the last round stage in place
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ROUND_COUNT] && m_tvalid && !m_tready)
        |=> (valid_reg[ROUND_COUNT] && $stable(stage_reg[ROUND_COUNT])))
        else $error("last round stage lost during stall");

    // An empty input stage always offers room upstream
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> s_tready)
        else $error("input refused with empty first stage");

endmodule

`default_nettype wire
